/* rtl/core/pli_pkg.sv */
// shared types and constants for the piecewise linear interpolator
// no dependencies
package pli_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned USER_W = 2;
  localparam int unsigned IN_W   = 64;
  localparam int unsigned OUT_W  = 40;

  // segment request from the scanner to the arithmetic unit
  typedef struct packed {
    logic signed [DATA_W-1:0] xl;
    logic signed [DATA_W-1:0] xr;
    logic signed [DATA_W-1:0] yl;
    logic signed [DATA_W-1:0] yr;
    logic signed [DATA_W-1:0] x;
  } seg_t;

endpackage

/* rtl/core/pli_calc.sv */
// segment arithmetic: dy*(x-xl) by shift-add, then restoring division by dx
// depends on pli_pkg
module pli_calc (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  pli_pkg::seg_t               seg,
  output logic                        done,
  output logic signed [31:0]          y_out
);
  import pli_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_MUL, C_DIV, C_DONE} cstate_t;

  cstate_t             state_r;
  logic [6:0]          cnt_r;
  logic [32:0]         mag_r;     // |dy|
  logic [32:0]         dxq_r;     // x - xl, multiplier bits
  logic [65:0]         prod_r;    // shift-add accumulator, later dividend
  logic [32:0]         dx_r;
  logic [33:0]         rem_r;
  logic [32:0]         quo_r;
  logic                neg_r;
  logic signed [31:0]  yl_r;

  logic signed [32:0]  dy_w, dx_w, dxq_w;
  logic [33:0]         rem_sh;
  logic [33:0]         rem_sub;
  logic signed [33:0]  sum_w;

  assign dy_w   = 33'(seg.yr) - 33'(seg.yl);
  assign dx_w   = 33'(seg.xr) - 33'(seg.xl);
  assign dxq_w  = 33'(seg.x)  - 33'(seg.xl);
  assign rem_sh = {rem_r[32:0], prod_r[65]};
  assign rem_sub = rem_sh - {1'b0, dx_r};
  assign sum_w  = neg_r ? (34'(yl_r) - 34'(quo_r)) : (34'(yl_r) + 34'(quo_r));

  // sequencer: 33 multiply steps then 66 divide steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done    <= 1'b0;
    end else begin
      done <= (state_r == C_DONE);
      unique case (state_r)
        C_IDLE: if (start) begin
          mag_r  <= dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
          dxq_r  <= 33'(dxq_w);
          dx_r   <= 33'(dx_w);
          neg_r  <= dy_w[32];
          yl_r   <= seg.yl;
          prod_r <= '0;
          cnt_r  <= '0;
          if (dx_w == '0) begin
            y_out   <= seg.yl;
            state_r <= C_DONE;
          end else begin
            state_r <= C_MUL;
          end
        end
        C_MUL: begin
          prod_r <= dxq_r[32] ? ((prod_r << 1) + 66'(mag_r)) : (prod_r << 1);
          dxq_r  <= dxq_r << 1;
          if (cnt_r == 7'd32) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            quo_r   <= '0;
            state_r <= C_DIV;
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        C_DIV: begin
          prod_r <= prod_r << 1;
          if (!rem_sub[33]) begin
            rem_r <= rem_sub;
            quo_r <= {quo_r[31:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[31:0], 1'b0};
          end
          if (cnt_r == 7'd65) begin
            cnt_r   <= '0;
            state_r <= C_DONE;
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        C_DONE: begin
          y_out   <= (dx_r == '0) ? yl_r : sum_w[31:0];
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/piecewise_linear_interpolator.sv */
// top level: breakpoint memories, segment scanner, output register
// depends on pli_pkg and pli_calc
//
// channel | dir | fields (low bit up)
// in_     | in  | tuser: mode[1:0]; tdata: x_value[31:0], y_value[63:32]
// out_    | out | tdata: y_result[31:0], hit[32], table_full[33]
//
// a clear returns no result; an append, or a query on fewer than two points,
// has its result valid the cycle after the transfer. a query otherwise scans
// every stored point (read, check, advance) and runs the calculator for
// each containing segment (start, 33 multiply steps, 66 divide steps, finish,
// handoff). reset empties the table; the memories need no clear.
// the input waits while an item is at work or its result is not taken.
module piecewise_linear_interpolator #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [pli_pkg::USER_W-1:0]  in_tuser,   // mode
  input  logic [pli_pkg::IN_W-1:0]    in_tdata,   // x_value, y_value
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pli_pkg::OUT_W-1:0]   out_tdata   // y_result, hit, table_full
);
  import pli_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_CHECK, S_CALC, S_WAIT, S_OUT} state_t;

  logic [DATA_W-1:0] xmem [MAX_POINTS];
  logic [DATA_W-1:0] ymem [MAX_POINTS];

  state_t              state_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       idx_r;
  logic signed [31:0]  qx_r;
  logic signed [31:0]  xprev_r, yprev_r;
  logic signed [31:0]  xrd_r, yrd_r;
  logic signed [31:0]  yres_r;
  logic                hit_r, full_r;
  logic                start_r;
  seg_t                seg_r;
  logic                calc_done;
  logic signed [31:0]  calc_y;
  logic [1:0]          mode_w;
  logic                seg_hit;

  assign mode_w    = in_tuser;
  assign in_tready = (state_r == S_IDLE) && !out_tvalid;
  assign out_tdata = {6'd0, full_r, hit_r, yres_r};
  assign seg_hit   = (idx_r != '0) && (qx_r >= xprev_r) && (qx_r <= xrd_r);

  pli_calc u_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .seg   (seg_r),
    .done  (calc_done),
    .y_out (calc_y)
  );

  // memory write on append, registered read during the scan
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready && mode_w == MODE_APPEND && count_r < CW'(MAX_POINTS)) begin
      xmem[count_r[AW-1:0]] <= in_tdata[31:0];
      ymem[count_r[AW-1:0]] <= in_tdata[63:32];
    end
    xrd_r <= xmem[idx_r[AW-1:0]];
    yrd_r <= ymem[idx_r[AW-1:0]];
  end

  // scan sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      out_tvalid <= 1'b0;
      start_r    <= 1'b0;
      idx_r      <= '0;
    end else begin
      start_r <= (state_r == S_CHECK) && seg_hit;
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          unique case (mode_t'(mode_w))
            MODE_CLEAR: count_r <= '0;
            MODE_APPEND: begin
              yres_r <= '0;
              hit_r  <= 1'b0;
              if (count_r < CW'(MAX_POINTS)) begin
                count_r <= count_r + 1'b1;
                full_r  <= 1'b0;
              end else begin
                full_r <= 1'b1;
              end
              out_tvalid <= 1'b1;
            end
            MODE_QUERY: begin
              qx_r   <= in_tdata[31:0];
              yres_r <= '0;
              hit_r  <= 1'b0;
              full_r <= 1'b0;
              idx_r  <= '0;
              if (count_r < CW'(2)) out_tvalid <= 1'b1;
              else state_r <= S_READ;
            end
            default: ;
          endcase
        end
        S_READ: state_r <= S_CHECK;
        S_CHECK: begin
          xprev_r <= xrd_r;
          yprev_r <= yrd_r;
          if (seg_hit) begin
            seg_r   <= '{xl: xprev_r, xr: xrd_r, yl: yprev_r, yr: yrd_r, x: qx_r};
            state_r <= S_CALC;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_CALC: state_r <= S_WAIT;
        S_WAIT: if (calc_done) begin
          yres_r  <= calc_y;
          hit_r   <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (idx_r + 1'b1 >= count_r) begin
            out_tvalid <= 1'b1;
            state_r    <= S_IDLE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_READ;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
